[src/cagn_pkg.sv]
// ----------------------------------------------------------------------------
// cagn_pkg
// Shared types, sizes and helpers of the class-aware greedy nms block.
// ----------------------------------------------------------------------------
package cagn_pkg;

	localparam int MAX_DET  = 64;
	localparam int COORD_W  = 12;
	localparam int LABEL_W  = 8;
	localparam int SCORE_W  = 16;
	localparam int IDX_W    = $clog2(MAX_DET);
	localparam int CNT_W    = $clog2(MAX_DET + 1);
	localparam int Q_DEPTH  = 4;
	localparam int QPTR_W   = $clog2(Q_DEPTH);
	localparam int CFG_W    = 16;
	localparam int CFG_IDX_W = 2;
	localparam int AREA_W   = 2 * COORD_W;
	localparam int UNI_W    = AREA_W + 1;
	localparam int PROD_W   = UNI_W + CFG_W;
	localparam int BOX_W    = 4 * COORD_W;
	localparam int SL_W     = SCORE_W + LABEL_W;

	localparam logic [CFG_IDX_W-1:0] CFG_IOU      = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_CONF     = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MIN_KEEP = 2'd2;

	localparam logic [CFG_W-1:0] IOU_RESET      = 16'd29491;
	localparam logic [CFG_W-1:0] CONF_RESET     = 16'd32768;
	localparam logic [CFG_W-1:0] MIN_KEEP_RESET = 16'd6554;

	typedef struct packed {
		logic [COORD_W-1:0] box_left;
		logic [COORD_W-1:0] box_top;
		logic [COORD_W-1:0] box_right;
		logic [COORD_W-1:0] box_bottom;
		logic [SCORE_W-1:0] box_score;
		logic [LABEL_W-1:0] box_label;
		logic               set_last;
	} det_t;

	typedef struct packed {
		logic [COORD_W-1:0] out_left;
		logic [COORD_W-1:0] out_top;
		logic [COORD_W-1:0] out_right;
		logic [COORD_W-1:0] out_bottom;
		logic [SCORE_W-1:0] out_score;
		logic [LABEL_W-1:0] out_label;
		logic               none_kept;
		logic               overflowed;
		logic               run_last;
	} result_t;

	typedef struct packed {
		logic [COORD_W-1:0] left;
		logic [COORD_W-1:0] top;
		logic [COORD_W-1:0] right;
		logic [COORD_W-1:0] bottom;
	} box_t;

	typedef struct packed {
		det_t             det;
		logic             drop;
		logic [IDX_W-1:0] slot;
	} qentry_t;

	typedef struct packed {
		logic [CFG_W-1:0] iou;
		logic [CFG_W-1:0] conf;
		logic [CFG_W-1:0] min_keep;
	} cfg_t;

	function automatic logic [COORD_W-1:0] span(input logic [COORD_W-1:0] lo,
		input logic [COORD_W-1:0] hi);
		return (hi > lo) ? (hi - lo) : '0;
	endfunction

endpackage

[src/cagn_ram.sv]
// ----------------------------------------------------------------------------
// cagn_ram
// Simple dual-port RAM, one write port and one registered read port.
// ----------------------------------------------------------------------------
module cagn_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

[src/cagn_front.sv]
// ----------------------------------------------------------------------------
// cagn_front
// Accepts detections, assigns store slots, flags overflow, queues requests.
// ----------------------------------------------------------------------------
module cagn_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	output logic              full,
	input  cagn_pkg::det_t    det,
	output logic              q_valid,
	output cagn_pkg::qentry_t q_entry,
	input  logic              q_pop
);

	logic [cagn_pkg::CNT_W-1:0]  cnt_q;
	cagn_pkg::qentry_t           mem_q [cagn_pkg::Q_DEPTH];
	logic [cagn_pkg::QPTR_W-1:0] wp_q;
	logic [cagn_pkg::QPTR_W-1:0] rp_q;
	logic [cagn_pkg::QPTR_W:0]   fill_q;
	logic                        acc;
	logic                        drop;
	cagn_pkg::qentry_t           new_entry;

	assign full    = (fill_q == (cagn_pkg::QPTR_W + 1)'(cagn_pkg::Q_DEPTH));
	assign acc     = push & ~full;
	assign q_valid = (fill_q != '0);
	assign q_entry = mem_q[rp_q];
	assign drop    = (cnt_q == cagn_pkg::CNT_W'(cagn_pkg::MAX_DET));

	always_comb begin
		new_entry.det  = det;
		new_entry.drop = drop;
		new_entry.slot = cnt_q[cagn_pkg::IDX_W-1:0];
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			mem_q[wp_q] <= new_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			wp_q   <= '0;
			rp_q   <= '0;
			fill_q <= '0;
		end else begin
			if (acc) begin
				wp_q <= wp_q + 1'b1;
				if (det.set_last) begin
					cnt_q <= '0;
				end else if (!drop) begin
					cnt_q <= cnt_q + 1'b1;
				end
			end
			if (q_pop) begin
				rp_q <= rp_q + 1'b1;
			end
			fill_q <= fill_q + (cagn_pkg::QPTR_W + 1)'(acc) - (cagn_pkg::QPTR_W + 1)'(q_pop);
		end
	end

endmodule

[src/cagn_back.sv]
// ----------------------------------------------------------------------------
// cagn_back
// Stores a set, then picks boxes in score order and suppresses overlaps.
// ----------------------------------------------------------------------------
module cagn_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              q_valid,
	input  cagn_pkg::qentry_t q_entry,
	output logic              q_pop,
	input  cagn_pkg::cfg_t    cfg,
	output logic              res_valid,
	output cagn_pkg::result_t res,
	input  logic              res_pop
);

	localparam logic [2:0] ST_LOAD   = 3'd0;
	localparam logic [2:0] ST_SCAN   = 3'd1;
	localparam logic [2:0] ST_DRAIN  = 3'd2;
	localparam logic [2:0] ST_DECIDE = 3'd3;
	localparam logic [2:0] ST_EMIT   = 3'd4;
	localparam logic [2:0] ST_FINISH = 3'd5;

	typedef struct packed {
		cagn_pkg::box_t                 box;
		logic [cagn_pkg::SCORE_W-1:0]   score;
		logic [cagn_pkg::LABEL_W-1:0]   label;
		logic [cagn_pkg::IDX_W-1:0]     idx;
	} ent_t;

	function automatic cagn_pkg::result_t mk_res(input ent_t e, input logic last,
		input logic ovf);
		cagn_pkg::result_t r;
		r.out_left   = e.box.left;
		r.out_top    = e.box.top;
		r.out_right  = e.box.right;
		r.out_bottom = e.box.bottom;
		r.out_score  = e.score;
		r.out_label  = e.label;
		r.none_kept  = 1'b0;
		r.overflowed = ovf;
		r.run_last   = last;
		return r;
	endfunction

	logic [2:0]                   state_q;
	logic [cagn_pkg::CNT_W-1:0]   n_q;
	logic [cagn_pkg::CNT_W-1:0]   j_q;
	logic                         ovf_q;
	logic [cagn_pkg::MAX_DET-1:0] visited_q;
	logic [cagn_pkg::MAX_DET-1:0] supp_q;
	logic                         best_v_q;
	ent_t                         best_q;
	ent_t                         cand_q;
	logic                         cand_act_q;
	logic [cagn_pkg::AREA_W-1:0]  area_a_q;
	logic                         pend_v_q;
	ent_t                         pend_q;
	logic                         out_v_q;
	cagn_pkg::result_t            out_q;

	logic                          issue;
	logic                          out_free;
	logic [cagn_pkg::BOX_W-1:0]    box_rd;
	logic [cagn_pkg::SL_W-1:0]     sl_rd;
	cagn_pkg::box_t                box_wr;
	cagn_pkg::box_t                b;
	logic [cagn_pkg::COORD_W-1:0]  il, it, ir, ib;
	cagn_pkg::result_t             none_res;

	logic                          v_s1, v_s2, v_s3, v_s4, v_s5;
	logic [cagn_pkg::IDX_W-1:0]    idx_s1;
	ent_t                          e_s2, e_s3, e_s4, e_s5;
	logic                          leq_s2, leq_s3, leq_s4, leq_s5;
	logic [cagn_pkg::COORD_W-1:0]  wb_s2, hb_s2, wi_s2, hi_s2;
	logic [cagn_pkg::AREA_W-1:0]   area_b_s3, inter_s3, inter_s4;
	logic [cagn_pkg::UNI_W-1:0]    uni_s4;
	logic [cagn_pkg::PROD_W-1:0]   lhs_s5, rhs_s5;
	logic                          uz_s5;
	logic                          hit, elig, better;

	assign q_pop     = (state_q == ST_LOAD) & q_valid;
	assign issue     = (state_q == ST_SCAN) & (j_q < n_q);
	assign out_free  = ~out_v_q | res_pop;
	assign res_valid = out_v_q;
	assign res       = out_q;

	always_comb begin
		box_wr.left   = q_entry.det.box_left;
		box_wr.top    = q_entry.det.box_top;
		box_wr.right  = q_entry.det.box_right;
		box_wr.bottom = q_entry.det.box_bottom;
		none_res            = '0;
		none_res.none_kept  = 1'b1;
		none_res.overflowed = ovf_q;
		none_res.run_last   = 1'b1;
	end

	cagn_ram #(.WIDTH(cagn_pkg::BOX_W), .DEPTH(cagn_pkg::MAX_DET)) u_box_ram (
		.clk   (clk),
		.we    (q_pop & ~q_entry.drop),
		.waddr (q_entry.slot),
		.wdata (box_wr),
		.raddr (j_q[cagn_pkg::IDX_W-1:0]),
		.rdata (box_rd)
	);

	cagn_ram #(.WIDTH(cagn_pkg::SL_W), .DEPTH(cagn_pkg::MAX_DET)) u_sl_ram (
		.clk   (clk),
		.we    (q_pop & ~q_entry.drop),
		.waddr (q_entry.slot),
		.wdata ({q_entry.det.box_score, q_entry.det.box_label}),
		.raddr (j_q[cagn_pkg::IDX_W-1:0]),
		.rdata (sl_rd)
	);

	// intersection corners against the current candidate
	always_comb begin
		b  = box_rd;
		il = (cand_q.box.left > b.left) ? cand_q.box.left : b.left;
		it = (cand_q.box.top > b.top) ? cand_q.box.top : b.top;
		ir = (cand_q.box.right < b.right) ? cand_q.box.right : b.right;
		ib = (cand_q.box.bottom < b.bottom) ? cand_q.box.bottom : b.bottom;
	end

	always_ff @(posedge clk) begin
		idx_s1 <= j_q[cagn_pkg::IDX_W-1:0];

		e_s2.box   <= b;
		e_s2.score <= sl_rd[cagn_pkg::SL_W-1:cagn_pkg::LABEL_W];
		e_s2.label <= sl_rd[cagn_pkg::LABEL_W-1:0];
		e_s2.idx   <= idx_s1;
		leq_s2     <= (sl_rd[cagn_pkg::LABEL_W-1:0] == cand_q.label);
		wb_s2      <= cagn_pkg::span(b.left, b.right);
		hb_s2      <= cagn_pkg::span(b.top, b.bottom);
		wi_s2      <= cagn_pkg::span(il, ir);
		hi_s2      <= cagn_pkg::span(it, ib);

		e_s3      <= e_s2;
		leq_s3    <= leq_s2;
		area_b_s3 <= cagn_pkg::AREA_W'(wb_s2) * cagn_pkg::AREA_W'(hb_s2);
		inter_s3  <= cagn_pkg::AREA_W'(wi_s2) * cagn_pkg::AREA_W'(hi_s2);

		e_s4     <= e_s3;
		leq_s4   <= leq_s3;
		inter_s4 <= inter_s3;
		uni_s4   <= {1'b0, area_a_q} + {1'b0, area_b_s3} - {1'b0, inter_s3};

		e_s5   <= e_s4;
		leq_s5 <= leq_s4;
		lhs_s5 <= cagn_pkg::PROD_W'({inter_s4, {cagn_pkg::CFG_W{1'b0}}});
		rhs_s5 <= cagn_pkg::PROD_W'(cfg.iou) * cagn_pkg::PROD_W'(uni_s4);
		uz_s5  <= (uni_s4 == '0);
	end

	always_comb begin
		hit    = v_s5 & cand_act_q & leq_s5 & ~uz_s5 & (lhs_s5 >= rhs_s5);
		elig   = v_s5 & ~visited_q[e_s5.idx] & ~supp_q[e_s5.idx] & ~hit;
		better = elig & (~best_v_q | (e_s5.score > best_q.score));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_LOAD;
			n_q        <= '0;
			j_q        <= '0;
			ovf_q      <= 1'b0;
			visited_q  <= '0;
			supp_q     <= '0;
			best_v_q   <= 1'b0;
			best_q     <= '0;
			cand_q     <= '0;
			cand_act_q <= 1'b0;
			area_a_q   <= '0;
			pend_v_q   <= 1'b0;
			pend_q     <= '0;
			out_v_q    <= 1'b0;
			out_q      <= '0;
			v_s1       <= 1'b0;
			v_s2       <= 1'b0;
			v_s3       <= 1'b0;
			v_s4       <= 1'b0;
			v_s5       <= 1'b0;
		end else begin
			v_s1 <= issue;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			if (hit) begin
				supp_q[e_s5.idx] <= 1'b1;
			end
			if (better) begin
				best_v_q <= 1'b1;
				best_q   <= e_s5;
			end
			if (res_pop && out_v_q) begin
				out_v_q <= 1'b0;
			end
			unique case (state_q)
				ST_LOAD: begin
					if (q_pop) begin
						if (q_entry.drop) begin
							ovf_q <= 1'b1;
						end else begin
							n_q <= {1'b0, q_entry.slot} + 1'b1;
						end
						if (q_entry.det.set_last) begin
							state_q    <= ST_SCAN;
							j_q        <= '0;
							best_v_q   <= 1'b0;
							cand_act_q <= 1'b0;
						end
					end
				end
				ST_SCAN: begin
					if (issue) begin
						j_q <= j_q + 1'b1;
					end
					if ((j_q + 1'b1) >= n_q) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (!(v_s1 | v_s2 | v_s3 | v_s4 | v_s5)) begin
						state_q <= ST_DECIDE;
					end
				end
				ST_DECIDE: begin
					if (!best_v_q || (best_q.score < cfg.min_keep)) begin
						state_q <= ST_FINISH;
					end else begin
						cand_q     <= best_q;
						cand_act_q <= 1'b1;
						visited_q[best_q.idx] <= 1'b1;
						area_a_q   <= cagn_pkg::AREA_W'(cagn_pkg::span(best_q.box.left,
							best_q.box.right)) * cagn_pkg::AREA_W'(cagn_pkg::span(
							best_q.box.top, best_q.box.bottom));
						j_q        <= '0;
						best_v_q   <= 1'b0;
						state_q    <= (best_q.score > cfg.conf) ? ST_EMIT : ST_SCAN;
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						if (pend_v_q) begin
							out_q   <= mk_res(pend_q, 1'b0, ovf_q);
							out_v_q <= 1'b1;
						end
						pend_q   <= cand_q;
						pend_v_q <= 1'b1;
						state_q  <= ST_SCAN;
					end
				end
				ST_FINISH: begin
					if (out_free) begin
						out_q      <= pend_v_q ? mk_res(pend_q, 1'b1, ovf_q) : none_res;
						out_v_q    <= 1'b1;
						n_q        <= '0;
						ovf_q      <= 1'b0;
						visited_q  <= '0;
						supp_q     <= '0;
						pend_v_q   <= 1'b0;
						cand_act_q <= 1'b0;
						state_q    <= ST_LOAD;
					end
				end
				default: begin
					state_q <= ST_LOAD;
				end
			endcase
		end
	end

endmodule

[src/class_aware_greedy_nms.sv]
// ----------------------------------------------------------------------------
// class_aware_greedy_nms
// Per-class greedy non-maximum suppression over a loaded set of detections.
//
//   channel   direction  handshake          payload
//   detection in         push / full        det_t
//   result    out        pop / empty        result_t
//   config    in         cfg_wen            cfg_index, cfg_data
//
// Loading takes one detection per cycle through a four-entry request queue
// while full is low. After the last detection each selection pass reads the
// n stored entries through the read ports of the two RAMs and a five-stage
// overlap pipeline: one pass per box that survives above min_keep_score, plus one.
// Reset is immediate; the box stores need no clearing pass.
// The result register lets the engine run on while a result waits to be popped.
// ----------------------------------------------------------------------------
module class_aware_greedy_nms (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 push,
	output logic                                 full,
	input  cagn_pkg::det_t                       detection,
	output logic                                 empty,
	input  logic                                 pop,
	output cagn_pkg::result_t                    result,
	input  logic                                 cfg_wen,
	input  logic [cagn_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [cagn_pkg::CFG_W-1:0]           cfg_data
);

	cagn_pkg::cfg_t    cfg_q;
	logic              q_valid;
	logic              q_pop;
	cagn_pkg::qentry_t q_entry;
	logic              res_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.iou      <= cagn_pkg::IOU_RESET;
			cfg_q.conf     <= cagn_pkg::CONF_RESET;
			cfg_q.min_keep <= cagn_pkg::MIN_KEEP_RESET;
		end else if (cfg_wen) begin
			unique case (cfg_index)
				cagn_pkg::CFG_IOU:      cfg_q.iou      <= cfg_data;
				cagn_pkg::CFG_CONF:     cfg_q.conf     <= cfg_data;
				cagn_pkg::CFG_MIN_KEEP: cfg_q.min_keep <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	cagn_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.full    (full),
		.det     (detection),
		.q_valid (q_valid),
		.q_entry (q_entry),
		.q_pop   (q_pop)
	);

	cagn_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_entry   (q_entry),
		.q_pop     (q_pop),
		.cfg       (cfg_q),
		.res_valid (res_valid),
		.res       (result),
		.res_pop   (pop)
	);

	assign empty = ~res_valid;

endmodule

[tb/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Checks class-aware greedy nms: sets of detection requests are pushed, a
// behavioral predictor sorts and suppresses each set and the popped results
// are compared field by field against it.
// ----------------------------------------------------------------------------
module tb;

	timeunit 1ns;
	timeprecision 1ps;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic push = 1'b0;
	logic full;
	cagn_pkg::det_t detection = '0;
	logic empty;
	logic pop = 1'b0;
	cagn_pkg::result_t result;
	logic cfg_wen = 1'b0;
	logic [cagn_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [cagn_pkg::CFG_W-1:0] cfg_data = '0;

	class_aware_greedy_nms u_top (.*);

	always #4 clk = ~clk;

	cagn_pkg::det_t pending_dets[$];
	cagn_pkg::result_t kept_boxes[$];
	cagn_pkg::det_t set_dets[$];
	logic [cagn_pkg::CFG_W-1:0] iou_thr = cagn_pkg::IOU_RESET;
	logic [cagn_pkg::CFG_W-1:0] conf_thr = cagn_pkg::CONF_RESET;
	logic [cagn_pkg::CFG_W-1:0] min_keep = cagn_pkg::MIN_KEEP_RESET;
	bit set_overflow;
	bit failed;
	int push_idle = 25, pop_idle = 25;
	longint unsigned cycles;

	function automatic logic [cagn_pkg::COORD_W-1:0] width_of(
		logic [cagn_pkg::COORD_W-1:0] lo, logic [cagn_pkg::COORD_W-1:0] hi);
		return (hi > lo) ? hi - lo : '0;
	endfunction

	function automatic bit overlap_hit(cagn_pkg::det_t a, cagn_pkg::det_t b);
		logic [63:0] area_a, area_b, inter, uni;
		logic [cagn_pkg::COORD_W-1:0] il, it, ir, ib;
		area_a = 64'(width_of(a.box_left, a.box_right))
			* 64'(width_of(a.box_top, a.box_bottom));
		area_b = 64'(width_of(b.box_left, b.box_right))
			* 64'(width_of(b.box_top, b.box_bottom));
		il = (a.box_left > b.box_left) ? a.box_left : b.box_left;
		it = (a.box_top > b.box_top) ? a.box_top : b.box_top;
		ir = (a.box_right < b.box_right) ? a.box_right : b.box_right;
		ib = (a.box_bottom < b.box_bottom) ? a.box_bottom : b.box_bottom;
		inter = 64'(width_of(il, ir)) * 64'(width_of(it, ib));
		uni = area_a + area_b - inter;
		if (uni == 0) return 1'b0;
		return (inter << 16) >= 64'(iou_thr) * uni;
	endfunction

	// accepted request: store it, and on set end predict the survivors
	task automatic take_detection(cagn_pkg::det_t d);
		cagn_pkg::det_t ord[$];
		bit gone[$];
		int j, k;
		cagn_pkg::result_t r;
		if (set_dets.size() < cagn_pkg::MAX_DET) set_dets.insert(set_dets.size(), d);
		else set_overflow = 1'b1;
		if (!d.set_last) return;
		foreach (set_dets[i]) begin
			j = ord.size();
			while (j > 0 && ord[j-1].box_score < set_dets[i].box_score) j--;
			ord.insert(j, set_dets[i]);
			gone.insert(gone.size(), 1'b0);
		end
		foreach (ord[i]) begin
			if (gone[i] || ord[i].box_score < min_keep) continue;
			for (j = i + 1; j < ord.size(); j++)
				if (!gone[j] && ord[i].box_label == ord[j].box_label
					&& overlap_hit(ord[i], ord[j]))
					gone[j] = 1'b1;
		end
		k = 0;
		foreach (ord[i]) begin
			if (!gone[i] && ord[i].box_score >= min_keep && ord[i].box_score > conf_thr) begin
				r = '0;
				r.out_left = ord[i].box_left;
				r.out_top = ord[i].box_top;
				r.out_right = ord[i].box_right;
				r.out_bottom = ord[i].box_bottom;
				r.out_score = ord[i].box_score;
				r.out_label = ord[i].box_label;
				r.overflowed = set_overflow;
				kept_boxes.insert(kept_boxes.size(), r);
				k++;
			end
		end
		if (k == 0) begin
			r = '0;
			r.none_kept = 1'b1;
			r.overflowed = set_overflow;
			kept_boxes.insert(kept_boxes.size(), r);
		end
		kept_boxes[$].run_last = 1'b1;
		set_dets.delete();
		set_overflow = 1'b0;
	endtask

	always @(posedge clk) begin
		if (push && !full) take_detection(detection);
		if (!(push && !full) && push) begin
		end else if (pending_dets.size() > 0 && $urandom_range(99) >= push_idle) begin
			push <= 1'b1;
			detection <= pending_dets.pop_front();
		end else begin
			push <= 1'b0;
		end
	end

	always @(posedge clk) begin
		if (pop && !empty) begin
			if (kept_boxes.size() == 0) begin
				$display("%0t: expected nothing actual %p", $time, result);
				failed = 1'b1;
			end else if (result !== kept_boxes[0]) begin
				$display("%0t: mismatch expected %p actual %p", $time, kept_boxes[0], result);
				failed = 1'b1;
				void'(kept_boxes.pop_front());
			end else begin
				void'(kept_boxes.pop_front());
			end
		end
		pop <= ($urandom_range(99) >= pop_idle);
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 2000000) begin
			$display("simulation failed");
			$finish;
		end
	end

	function automatic cagn_pkg::det_t rand_det(int label_max, bit last);
		cagn_pkg::det_t d;
		d.box_left = cagn_pkg::COORD_W'($urandom_range(4095));
		d.box_top = cagn_pkg::COORD_W'($urandom_range(4095));
		d.box_right = cagn_pkg::COORD_W'($urandom_range(4095));
		d.box_bottom = cagn_pkg::COORD_W'($urandom_range(4095));
		d.box_score = cagn_pkg::SCORE_W'($urandom_range(65535));
		d.box_label = cagn_pkg::LABEL_W'($urandom_range(label_max));
		d.set_last = last;
		return d;
	endfunction

	// clustered boxes so that overlaps and suppression really happen
	function automatic cagn_pkg::det_t near_det(cagn_pkg::det_t base, int label_max,
		bit last);
		cagn_pkg::det_t d;
		d = base;
		d.box_left = base.box_left + cagn_pkg::COORD_W'($urandom_range(20));
		d.box_top = base.box_top + cagn_pkg::COORD_W'($urandom_range(20));
		d.box_right = d.box_left + cagn_pkg::COORD_W'($urandom_range(30, 120));
		d.box_bottom = d.box_top + cagn_pkg::COORD_W'($urandom_range(30, 120));
		d.box_score = ($urandom_range(3) == 0) ? base.box_score
			: cagn_pkg::SCORE_W'($urandom_range(65535));
		d.box_label = cagn_pkg::LABEL_W'($urandom_range(label_max));
		d.set_last = last;
		return d;
	endfunction

	task automatic write_reg(logic [cagn_pkg::CFG_IDX_W-1:0] idx,
		logic [cagn_pkg::CFG_W-1:0] val);
		@(posedge clk);
		cfg_wen <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_wen <= 1'b0;
		case (idx)
			cagn_pkg::CFG_IOU: iou_thr = val;
			cagn_pkg::CFG_CONF: conf_thr = val;
			cagn_pkg::CFG_MIN_KEEP: min_keep = val;
			default: ;
		endcase
	endtask

	task automatic drain;
		while (pending_dets.size() != 0 || push || kept_boxes.size() != 0)
			@(posedge clk);
		repeat (600) @(posedge clk);
	endtask

	task automatic random_sets(int n_items);
		cagn_pkg::det_t base;
		int sz, lm;
		while (n_items > 0) begin
			sz = ($urandom_range(15) == 0) ? $urandom_range(60, 70) : $urandom_range(1, 12);
			lm = ($urandom_range(3) == 0) ? 255 : $urandom_range(2);
			base = rand_det(lm, 1'b0);
			base.box_left = cagn_pkg::COORD_W'($urandom_range(3800));
			base.box_top = cagn_pkg::COORD_W'($urandom_range(3800));
			for (int i = 0; i < sz; i++) begin
				if ($urandom_range(4) == 0)
					pending_dets.insert(pending_dets.size(), rand_det(lm, i == sz - 1));
				else
					pending_dets.insert(pending_dets.size(), near_det(base, lm, i == sz - 1));
			end
			n_items -= sz;
		end
	endtask

	initial begin
		cagn_pkg::det_t d;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		write_reg(cagn_pkg::CFG_IDX_W'(3), 16'h1234);
		// directed: field extremes, inverted and zero-area boxes, ties, overflow
		d = '0; d.box_score = 16'hffff; d.box_label = 8'hff;
		d.box_right = 12'hfff; d.box_bottom = 12'hfff;
		pending_dets.insert(pending_dets.size(), d);
		pending_dets.insert(pending_dets.size(), d);
		d.box_left = 12'hfff; d.box_top = 12'hfff; d.box_right = '0; d.box_bottom = '0;
		pending_dets.insert(pending_dets.size(), d);
		d = '0; d.set_last = 1'b1;
		pending_dets.insert(pending_dets.size(), d);
		d.box_score = 16'd40000;
		pending_dets.insert(pending_dets.size(), d);
		for (int i = 0; i < 66; i++) begin
			d = rand_det(1, i == 65);
			if (i == 65) d.box_score = 16'hffff;
			pending_dets.insert(pending_dets.size(), d);
		end
		drain();
		write_reg(cagn_pkg::CFG_IOU, 16'd0);
		write_reg(cagn_pkg::CFG_CONF, 16'd0);
		write_reg(cagn_pkg::CFG_MIN_KEEP, 16'd0);
		random_sets(60);
		drain();
		write_reg(cagn_pkg::CFG_IOU, 16'hffff);
		write_reg(cagn_pkg::CFG_CONF, 16'hffff);
		write_reg(cagn_pkg::CFG_MIN_KEEP, 16'hffff);
		random_sets(30);
		drain();
		write_reg(cagn_pkg::CFG_IOU, 16'd20000);
		write_reg(cagn_pkg::CFG_CONF, 16'd16000);
		write_reg(cagn_pkg::CFG_MIN_KEEP, 16'd8000);
		push_idle = 0;
		pop_idle = 0;
		random_sets(60);
		drain();
		push_idle = 25;
		pop_idle = 25;
		write_reg(cagn_pkg::CFG_IOU, cagn_pkg::IOU_RESET);
		write_reg(cagn_pkg::CFG_CONF, cagn_pkg::CONF_RESET);
		write_reg(cagn_pkg::CFG_MIN_KEEP, cagn_pkg::MIN_KEEP_RESET);
		random_sets(80);
		drain();
		if (!failed) $display("simulation ok");
		else $display("simulation failed");
		$finish;
	end

endmodule
